>>> rtl/core/pfc_pkg.sv
package pfc_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

  localparam logic [2:0] FMT_RGB32  = 3'd0;
  localparam logic [2:0] FMT_BF32   = 3'd1;
  localparam logic [2:0] FMT_RGB24  = 3'd2;
  localparam logic [2:0] FMT_RGB555 = 3'd3;
  localparam logic [2:0] FMT_BF16   = 3'd4;
  localparam logic [2:0] FMT_IDX8   = 3'd5;
  localparam logic [2:0] FMT_IDX4   = 3'd6;
  localparam logic [2:0] FMT_IDX1   = 3'd7;

  localparam logic [1:0] MODE_UNPACK = 2'd0;
  localparam logic [1:0] MODE_PACK   = 2'd1;
  localparam logic [1:0] MODE_PALWR  = 2'd2;

  localparam logic [2:0] REG_FORMAT  = 3'd0;
  localparam logic [2:0] REG_R_SHIFT = 3'd1;
  localparam logic [2:0] REG_R_LEN   = 3'd2;
  localparam logic [2:0] REG_G_SHIFT = 3'd3;
  localparam logic [2:0] REG_G_LEN   = 3'd4;
  localparam logic [2:0] REG_B_SHIFT = 3'd5;
  localparam logic [2:0] REG_B_LEN   = 3'd6;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 5;

  function automatic logic [7:0] chan_get(logic [31:0] v, logic [4:0] sh, logic [4:0] len);
    logic [31:0] mask;
    logic [31:0] f;
    logic [31:0] g;
    mask = ~(32'hffff_ffff << len);
    f    = (v >> sh) & mask;
    if (len >= 5'd8) begin
      g = f >> (len - 5'd8);
    end else begin
      g = f << (5'd8 - len);
    end
    return g[7:0];
  endfunction

  function automatic logic [31:0] chan_put(logic [7:0] b, logic [4:0] sh, logic [4:0] len);
    logic [31:0] f;
    f = {24'd0, b};
    if (len >= 5'd8) begin
      f = f << (len - 5'd8);
    end else begin
      f = f >> (5'd8 - len);
    end
    return f << sh;
  endfunction

endpackage

>>> rtl/core/pixel_format_converter.sv
// A request beat is registered in stage 1, then in the response register.
// Throughput: one beat per cycle unless rsp_stall backs up to req_stall.
// Reset (rst, synchronous): pipeline emptied, format registers return to
// XRGB8888 defaults. Palette contents are not cleared.
module pixel_format_converter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [1:0]                 mode,
  input  logic [31:0]                pixel_value,
  input  logic [7:0]                 palette_slot,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [31:0]                result_value,
  output logic                       error,
  input  logic                       cfg_we,
  input  logic [pfc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [pfc_pkg::CFG_DW-1:0] cfg_data
);
  import pfc_pkg::*;

  logic [2:0] pixel_format;
  logic [4:0] red_shift, red_len, green_shift, green_len, blue_shift, blue_len;

  logic        s1_valid;
  logic [31:0] s1_res;
  logic        s1_err;
  logic        s1_pal;
  logic        s1_adv;
  logic        accept;

  logic [7:0]        idx;
  logic              idx_ok;
  logic              slot_ok;
  logic              pal_we;
  logic [31:0]       pal_rdata;
  logic [31:0]       direct_res;
  logic              direct_err;
  logic              use_pal;
  logic [31:0]       bf_src;
  logic [31:0]       pk;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGB32;
      red_shift    <= 5'd16;
      red_len      <= 5'd8;
      green_shift  <= 5'd8;
      green_len    <= 5'd8;
      blue_shift   <= 5'd0;
      blue_len     <= 5'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT:  pixel_format <= cfg_data[2:0];
        REG_R_SHIFT: red_shift    <= cfg_data;
        REG_R_LEN:   red_len      <= cfg_data;
        REG_G_SHIFT: green_shift  <= cfg_data;
        REG_G_LEN:   green_len    <= cfg_data;
        REG_B_SHIFT: blue_shift   <= cfg_data;
        REG_B_LEN:   blue_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv    = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !s1_adv;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    case (pixel_format)
      FMT_IDX8: idx = pixel_value[7:0];
      FMT_IDX4: idx = {4'd0, pixel_value[3:0]};
      default:  idx = {7'd0, pixel_value[0]};
    endcase
  end

  assign idx_ok  = {1'b0, idx} < 9'(PAL_ENTRIES);
  assign slot_ok = {1'b0, palette_slot} < 9'(PAL_ENTRIES);
  assign pal_we  = accept && (mode == MODE_PALWR) && slot_ok;

  assign bf_src = (pixel_format == FMT_BF16) ? {16'd0, pixel_value[15:0]} : pixel_value;
  assign pk     = chan_put(pixel_value[23:16], red_shift, red_len) |
                  chan_put(pixel_value[15:8], green_shift, green_len) |
                  chan_put(pixel_value[7:0], blue_shift, blue_len);

  always_comb begin
    direct_res = 32'd0;
    direct_err = 1'b0;
    use_pal    = 1'b0;
    case (mode)
      MODE_UNPACK: begin
        case (pixel_format)
          FMT_RGB32:  direct_res = pixel_value;
          FMT_RGB24:  direct_res = {8'd0, pixel_value[23:0]};
          FMT_RGB555: direct_res = {8'd0, pixel_value[14:10], 3'd0, pixel_value[9:5], 3'd0,
                                    pixel_value[4:0], 3'd0};
          FMT_BF32, FMT_BF16: direct_res = {8'd0,
                                            chan_get(bf_src, red_shift, red_len),
                                            chan_get(bf_src, green_shift, green_len),
                                            chan_get(bf_src, blue_shift, blue_len)};
          default: use_pal = idx_ok;
        endcase
      end
      MODE_PACK: begin
        case (pixel_format)
          FMT_RGB32:  direct_res = pixel_value;
          FMT_BF32:   direct_res = pk;
          FMT_RGB24:  direct_res = {8'd0, pixel_value[23:0]};
          FMT_RGB555: direct_res = {17'd0, pixel_value[23:19], pixel_value[15:11],
                                    pixel_value[7:3]};
          FMT_BF16:   direct_res = {16'd0, pk[15:0]};
          default:    direct_err = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  pfc_ram #(
    .WIDTH(32),
    .DEPTH(PAL_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(palette_slot[PAL_AW-1:0]),
    .wdata(pixel_value),
    .re   (accept),
    .raddr(idx[PAL_AW-1:0]),
    .rdata(pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_res <= direct_res;
      s1_err <= direct_err;
      s1_pal <= use_pal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (s1_valid && s1_adv) begin
      result_value <= s1_pal ? pal_rdata : s1_res;
      error        <= s1_err;
    end
  end

endmodule

>>> rtl/core/pfc_ram.sv
module pfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pfc_checker.sv
module pfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] result_value,
  input logic        error
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(result_value) && $stable(error))
    else $error("response beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> result_value == 32'd0)
    else $error("error beat carries nonzero result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("request stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (.*);

>>> verif/tb_pixel_format_converter.sv
`timescale 1ns / 1ps

module tb_pixel_format_converter;
  import pfc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         PHASES      = 24;
  localparam int         PHASE_BEATS = 77;

  typedef struct packed {
    logic [2:0] fmt;
    logic [4:0] rs;
    logic [4:0] rl;
    logic [4:0] gs;
    logic [4:0] gl;
    logic [4:0] bs;
    logic [4:0] bl;
  } pix_cfg_t;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } pix_rsp_t;

  typedef struct packed {
    logic     on;
    pix_rsp_t r;
  } fixed_answer_t;

  typedef struct packed {
    logic [3:0]  sel;
    logic [1:0]  op;
    logic [31:0] value;
    logic [7:0]  slot;
    logic        typed;
    logic [31:0] want;
    logic        want_err;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [1:0]          mode;
  logic [31:0]         pixel_value;
  logic [7:0]          palette_slot;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [31:0]         result_value;
  logic                error;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;

  pix_cfg_t            cfg_now;
  logic [31:0]         pal_copy [PAL_ENTRIES];
  bit                  pal_seen [PAL_ENTRIES];
  pix_rsp_t            result_due_q [$];
  fixed_answer_t       fixed_answer_q [$];
  int                  in_flight;
  int                  mismatches;
  int                  quiet_cycles;
  logic                req_calm;

  pix_cfg_t dir_cfgs [9] = '{
    '{FMT_RGB32,  5'd16, 5'd8,  5'd8,  5'd8,  5'd0,  5'd8},
    '{FMT_BF32,   5'd31, 5'd16, 5'd0,  5'd1,  5'd20, 5'd8},
    '{FMT_BF16,   5'd11, 5'd5,  5'd5,  5'd6,  5'd0,  5'd5},
    '{FMT_BF32,   5'd4,  5'd0,  5'd24, 5'd16, 5'd31, 5'd1},
    '{FMT_RGB24,  5'd16, 5'd8,  5'd8,  5'd8,  5'd0,  5'd8},
    '{FMT_RGB555, 5'd16, 5'd8,  5'd8,  5'd8,  5'd0,  5'd8},
    '{FMT_IDX8,   5'd16, 5'd8,  5'd8,  5'd8,  5'd0,  5'd8},
    '{FMT_IDX4,   5'd16, 5'd8,  5'd8,  5'd8,  5'd0,  5'd8},
    '{FMT_IDX1,   5'd16, 5'd8,  5'd8,  5'd8,  5'd0,  5'd8}
  };

  dir_row_t dir_rows [26] = '{
    '{4'd0, MODE_UNPACK, 32'hffff_ffff, 8'h00, 1'b1, 32'hffff_ffff, 1'b0},
    '{4'd0, MODE_PACK,   32'h1234_5678, 8'hff, 1'b1, 32'h1234_5678, 1'b0},
    '{4'd0, MODE_UNUSED, 32'hffff_ffff, 8'hff, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd0, MODE_PALWR,  32'hffff_ffff, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd0, MODE_PALWR,  32'h0000_0000, 8'hff, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd0, MODE_PALWR,  32'h00a5_5a3c, 8'h01, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd0, MODE_PALWR,  32'h8012_3456, 8'h0f, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd1, MODE_UNPACK, 32'hffff_ffff, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd1, MODE_UNPACK, 32'h8000_0001, 8'h5a, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd1, MODE_PACK,   32'h00ff_ffff, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd1, MODE_PACK,   32'h0000_0000, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd2, MODE_UNPACK, 32'hffff_0000, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd2, MODE_UNPACK, 32'h0000_ffff, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd2, MODE_PACK,   32'hffff_ffff, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd3, MODE_UNPACK, 32'hffff_ffff, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd3, MODE_PACK,   32'hffff_ffff, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd4, MODE_UNPACK, 32'hffff_ffff, 8'h00, 1'b1, 32'h00ff_ffff, 1'b0},
    '{4'd4, MODE_PACK,   32'hab00_0000, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd5, MODE_UNPACK, 32'h0000_7fff, 8'h00, 1'b1, 32'h00f8_f8f8, 1'b0},
    '{4'd5, MODE_PACK,   32'hffff_ffff, 8'h00, 1'b1, 32'h0000_7fff, 1'b0},
    '{4'd6, MODE_UNPACK, 32'hffff_ffff, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
    '{4'd6, MODE_PACK,   32'h00ff_ffff, 8'h00, 1'b1, 32'h0000_0000, 1'b1},
    '{4'd7, MODE_UNPACK, 32'hffff_ff0f, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd8, MODE_UNPACK, 32'hffff_fffe, 8'h00, 1'b1, 32'hffff_ffff, 1'b0},
    '{4'd8, MODE_UNPACK, 32'h0000_0001, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
    '{4'd8, MODE_PACK,   32'h0000_0000, 8'h00, 1'b1, 32'h0000_0000, 1'b1}
  };

  pixel_format_converter i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .pixel_value  (pixel_value),
    .palette_slot (palette_slot),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_value (result_value),
    .error        (error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // channel byte from a field: top 8 bits, zero padded below when narrower
  function automatic logic [7:0] field_byte(logic [31:0] w, logic [4:0] pos, logic [4:0] width);
    logic [63:0] f;
    f = ({32'h0, w} >> pos) & ((64'd1 << width) - 64'd1);
    if (width >= 5'd8) begin
      f = f >> (width - 5'd8);
    end else begin
      f = f << (5'd8 - width);
    end
    return f[7:0];
  endfunction

  function automatic logic [31:0] byte_field(logic [7:0] b, logic [4:0] pos, logic [4:0] width);
    logic [63:0] f;
    f = {56'h0, b};
    if (width >= 5'd8) begin
      f = f << (width - 5'd8);
    end else begin
      f = f >> (5'd8 - width);
    end
    f = f << pos;
    return f[31:0];
  endfunction

  function automatic pix_rsp_t convert_pixel(logic [1:0] op, logic [31:0] v, logic [7:0] s);
    pix_rsp_t    r;
    logic [31:0] lo16;
    logic [31:0] xrgb32;
    logic [31:0] xrgb16;
    logic [31:0] packed_px;
    r = '0;
    lo16 = {16'h0, v[15:0]};
    xrgb32 = {8'h0, field_byte(v, cfg_now.rs, cfg_now.rl),
              field_byte(v, cfg_now.gs, cfg_now.gl), field_byte(v, cfg_now.bs, cfg_now.bl)};
    xrgb16 = {8'h0, field_byte(lo16, cfg_now.rs, cfg_now.rl),
              field_byte(lo16, cfg_now.gs, cfg_now.gl),
              field_byte(lo16, cfg_now.bs, cfg_now.bl)};
    packed_px = byte_field(v[23:16], cfg_now.rs, cfg_now.rl) |
                byte_field(v[15:8], cfg_now.gs, cfg_now.gl) |
                byte_field(v[7:0], cfg_now.bs, cfg_now.bl);
    case (op)
      MODE_UNPACK: begin
        case (cfg_now.fmt)
          FMT_RGB32:  r.value = v;
          FMT_BF32:   r.value = xrgb32;
          FMT_RGB24:  r.value = {8'h0, v[23:0]};
          FMT_RGB555: r.value = {8'h0, v[14:10], 3'b0, v[9:5], 3'b0, v[4:0], 3'b0};
          FMT_BF16:   r.value = xrgb16;
          FMT_IDX8:   r.value = pal_copy[v[7:0]];
          FMT_IDX4:   r.value = pal_copy[{4'h0, v[3:0]}];
          default:    r.value = pal_copy[{7'h0, v[0]}];
        endcase
      end
      MODE_PACK: begin
        case (cfg_now.fmt)
          FMT_RGB32:  r.value = v;
          FMT_BF32:   r.value = packed_px;
          FMT_RGB24:  r.value = {8'h0, v[23:0]};
          FMT_RGB555: r.value = {17'h0, v[23:19], v[15:11], v[7:3]};
          FMT_BF16:   r.value = {16'h0, packed_px[15:0]};
          default:    r.err = 1'b1;
        endcase
      end
      MODE_PALWR: pal_copy[s] = v;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] pick_pos();
    case ($urandom_range(0, 3))
      0:       return 5'd0;
      1:       return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [4:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return 5'd1;
      1:       return 5'd16;
      2:       return 5'd0;
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic load_format(pix_cfg_t c);
    req_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FORMAT;
    cfg_data  <= {2'b00, c.fmt};
    @(posedge clk);
    cfg_index <= REG_R_SHIFT;
    cfg_data  <= c.rs;
    @(posedge clk);
    cfg_index <= REG_R_LEN;
    cfg_data  <= c.rl;
    @(posedge clk);
    cfg_index <= REG_G_SHIFT;
    cfg_data  <= c.gs;
    @(posedge clk);
    cfg_index <= REG_G_LEN;
    cfg_data  <= c.gl;
    @(posedge clk);
    cfg_index <= REG_B_SHIFT;
    cfg_data  <= c.bs;
    @(posedge clk);
    cfg_index <= REG_B_LEN;
    cfg_data  <= c.bl;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cfg_now = c;
  endtask

  task automatic send_beat(logic [1:0] op, logic [31:0] v, logic [7:0] s, fixed_answer_t fa);
    int gap;
    gap = req_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    mode         <= op;
    pixel_value  <= v;
    palette_slot <= s;
    fixed_answer_q.push_back(fa);
    if (op == MODE_PALWR) pal_seen[s] = 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  initial begin
    pix_cfg_t    c;
    int          sel;
    int          r;
    int          hi;
    int          idx;
    logic [1:0]  op;
    logic [31:0] v;
    logic [7:0]  s;
    clk          = 1'b0;
    rst          = 1'b1;
    req_valid    = 1'b0;
    mode         = MODE_UNPACK;
    pixel_value  = '0;
    palette_slot = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_FORMAT;
    cfg_data     = '0;
    req_calm     = 1'b0;
    in_flight    = 0;
    mismatches   = 0;
    cfg_now      = dir_cfgs[0];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sel = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sel != sel) begin
        sel = dir_rows[i].sel;
        load_format(dir_cfgs[sel]);
      end
      send_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].slot,
                '{dir_rows[i].typed, '{dir_rows[i].want, dir_rows[i].want_err}});
    end

    for (int p = 0; p < PHASES; p++) begin
      c.fmt = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
      c.rs  = pick_pos();
      c.rl  = pick_width();
      c.gs  = pick_pos();
      c.gl  = pick_width();
      c.bs  = pick_pos();
      c.bl  = pick_width();
      load_format(c);
      req_calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        v = $urandom;
        s = 8'($urandom_range(0, 255));
        if (r < 12) op = MODE_PALWR;
        else if (r < 16) op = MODE_UNUSED;
        else if (r < 58) op = MODE_UNPACK;
        else op = MODE_PACK;
        // indexed reads only hit palette entries already loaded
        if (op == MODE_UNPACK && c.fmt >= FMT_IDX8) begin
          hi = (c.fmt == FMT_IDX8) ? 255 : (c.fmt == FMT_IDX4) ? 15 : 1;
          do idx = $urandom_range(0, hi); while (!pal_seen[idx]);
          v = (v & ~32'(hi)) | 32'(idx);
        end
        send_beat(op, v, s, '0);
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && result_due_q.size() == 0) begin
      $display("PASS pixel_format_converter");
    end else begin
      $display("FAIL pixel_format_converter");
    end
    $finish;
  end

  initial begin
    int   n;
    int   beats;
    logic calm;
    rsp_stall = 1'b0;
    beats     = 0;
    calm      = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (beats % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      n = calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
      beats++;
    end
  end

  always @(posedge clk) begin
    pix_rsp_t      e;
    fixed_answer_t fa;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        fa = fixed_answer_q.pop_front();
        e  = convert_pixel(mode, pixel_value, palette_slot);
        result_due_q.push_back(fa.on ? fa.r : e);
        in_flight++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (result_due_q.size() == 0) begin
          $error("unexpected beat: result_value %h error %b", result_value, error);
          mismatches++;
        end else begin
          e = result_due_q.pop_front();
          in_flight--;
          if (result_value !== e.value) begin
            $error("result_value expected %h actual %h", e.value, result_value);
            mismatches++;
          end
          if (error !== e.err) begin
            $error("error expected %b actual %b", e.err, error);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL pixel_format_converter");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
